// ===== hdl/psch_pkg.sv =====
`timescale 1ns / 1ps
package psch_pkg;

   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);
   localparam int SLOT_W    = 4;
   localparam int TCOUNT_W  = 5;
   localparam int FIELD_W   = 16;
   localparam int TIME_W    = 32;
   localparam int SUM_W     = 40;
   localparam int WIDE_W    = (CNT_W > TCOUNT_W) ? CNT_W : TCOUNT_W;
   localparam int CMP_W     = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

   localparam logic [TIME_W-1:0]   TIME_MAX      = '1;
   localparam logic [SUM_W-1:0]    SUM_MAX       = '1;
   localparam logic [TCOUNT_W-1:0] COUNT_MAX     = '1;
   localparam logic [TCOUNT_W-1:0] TCOUNT_RESET  = TCOUNT_W'(16);

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic               we;
      logic [SLOT_W-1:0]  slot;
      logic [FIELD_W-1:0] prio;
      logic [FIELD_W-1:0] arrival;
      logic [FIELD_W-1:0] burst;
   } load_type;

   typedef struct packed {
      logic             strobe;
      logic [IDX_W-1:0] slot;
   } dec_type;

   // best candidate so far, carried down the chain one cell per cycle
   typedef struct packed {
      logic               go;
      logic               found;
      logic [FIELD_W-1:0] prio;
      logic [IDX_W-1:0]   slot;
      logic [FIELD_W-1:0] arrival;
      logic [FIELD_W-1:0] burst;
      logic               last;
   } token_type;

endpackage

// ===== hdl/psch_if.sv =====
`timescale 1ns / 1ps
interface psch_req_if import psch_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [SLOT_W-1:0]  slot;
   logic [FIELD_W-1:0] task_priority;
   logic [FIELD_W-1:0] arrival;
   logic [FIELD_W-1:0] burst;

   modport source (output valid, mode, slot, task_priority, arrival, burst, input ready);
   modport sink (input valid, mode, slot, task_priority, arrival, burst, output ready);
endinterface

interface psch_rsp_if import psch_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              idle;
   logic [SLOT_W-1:0] ran_slot;
   logic              finished;
   logic [TIME_W-1:0] completion_time;
   logic [TIME_W-1:0] turnaround;
   logic [TIME_W-1:0] waiting;
   logic              all_done;
   logic [SUM_W-1:0]  total_waiting;
   logic [SUM_W-1:0]  total_turnaround;

   modport source (output valid, idle, ran_slot, finished, completion_time, turnaround,
                   waiting, all_done, total_waiting, total_turnaround, input ready);
   modport sink (input valid, idle, ran_slot, finished, completion_time, turnaround,
                 waiting, all_done, total_waiting, total_turnaround, output ready);
endinterface

interface psch_csr_if import psch_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TCOUNT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== hdl/preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
// Preemptive fixed-priority scheduler over MAX_TASKS task slots.
// req_ch: mode 0 loads a slot (priority, arrival, burst) and gives no result;
//   mode 1 is one time tick and gives exactly one item on rsp_ch.
// csr_ch: writes task_count (slots taking part); always ready, write only
//   while no tick is in flight.
// A load is registered straight into its slot cell. A tick walks a candidate
// token down a chain of MAX_TASKS slot cells, one cell per cycle, then steps
// through ST_CALC (time and turnaround) and ST_SUM (waiting and the running
// sums), where the result is registered. The next item is taken once the
// scheduler is back in ST_IDLE; no load or tick is accepted while a tick is
// still in progress, so the length of the cell chain sets the pace of ticks.
// The result sits in an output register; loads are still accepted while it
// waits. A following tick runs its scan and then holds in its last step
// until the receiver has taken the earlier result.
// Synchronous reset clears all slots to invalid, time, completion count and
// sums to zero, and task_count to 16.
module preemptive_priority_scheduler import psch_pkg::*; (
   input logic clock,
   input logic reset,
   psch_req_if.sink   req_ch,
   psch_rsp_if.source rsp_ch,
   psch_csr_if.sink   csr_ch
);

   state_type           state_ff, state_in;
   logic [TCOUNT_W-1:0] task_count_ff;
   logic [TIME_W-1:0]   time_ff;
   logic [TCOUNT_W-1:0] completed_ff;
   logic [SUM_W-1:0]    sum_wait_ff;
   logic [SUM_W-1:0]    sum_tat_ff;
   token_type           pick_ff;
   logic                fin_ff;
   logic [TIME_W-1:0]   comp_ff;
   logic [TIME_W-1:0]   tat_ff;

   logic                rsp_valid_ff;
   logic                rsp_idle_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_fin_ff;
   logic [TIME_W-1:0]   rsp_comp_ff;
   logic [TIME_W-1:0]   rsp_tat_ff;
   logic [TIME_W-1:0]   rsp_wait_ff;
   logic                rsp_done_ff;
   logic [SUM_W-1:0]    rsp_sum_wait_ff;
   logic [SUM_W-1:0]    rsp_sum_tat_ff;

   logic [WIDE_W-1:0]   count_wide;
   logic [CNT_W-1:0]    active;
   logic                req_ready;
   logic                req_take;
   logic                tick_take;
   logic                rsp_free;
   load_type            load;
   dec_type             dec;
   token_type           tok [MAX_TASKS+1];
   logic [TIME_W-1:0]   time_next;
   logic [TIME_W-1:0]   wait_val;
   logic [SUM_W:0]      sum_wait_raw;
   logic [SUM_W:0]      sum_tat_raw;

   assign count_wide = WIDE_W'(task_count_ff);
   assign active     = (count_wide > WIDE_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                         : CNT_W'(count_wide);
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (tick_take) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tok[MAX_TASKS].go) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: state_in = ST_SUM;
         ST_SUM: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      req_take   = req_ready && req_ch.valid;
      tick_take  = req_take && (req_ch.mode == MODE_TICK);
      load.we      = req_take && (req_ch.mode == MODE_LOAD);
      load.slot    = req_ch.slot;
      load.prio    = req_ch.task_priority;
      load.arrival = req_ch.arrival;
      load.burst   = req_ch.burst;
      dec.strobe = (state_ff == ST_CALC) && pick_ff.found;
      dec.slot   = pick_ff.slot;
   end

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      tok[0]    = '0;
      tok[0].go = tick_take;
   end

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      psch_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .idx      (IDX_W'(i)),
         .active   (active),
         .cur_time (time_ff),
         .load     (load),
         .dec      (dec),
         .tok_in   (tok[i]),
         .tok_out  (tok[i+1])
      );
   end

   assign time_next    = (time_ff != TIME_MAX) ? (time_ff + TIME_W'(1)) : time_ff;
   assign wait_val     = (fin_ff && (tat_ff >= TIME_W'(pick_ff.burst)))
                         ? (tat_ff - TIME_W'(pick_ff.burst)) : '0;
   assign sum_wait_raw = (SUM_W+1)'(sum_wait_ff) + (SUM_W+1)'(wait_val);
   assign sum_tat_raw  = (SUM_W+1)'(sum_tat_ff) + (SUM_W+1)'(tat_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         task_count_ff <= TCOUNT_RESET;
         time_ff       <= '0;
         completed_ff  <= '0;
         sum_wait_ff   <= '0;
         sum_tat_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_ch.valid) begin
            task_count_ff <= csr_ch.data;
         end
         if (state_ff == ST_CALC) begin
            time_ff <= time_next;
            if (pick_ff.found && pick_ff.last && (completed_ff != COUNT_MAX)) begin
               completed_ff <= completed_ff + TCOUNT_W'(1);
            end
         end
         if ((state_ff == ST_SUM) && rsp_free) begin
            sum_wait_ff  <= sum_wait_raw[SUM_W] ? SUM_MAX : sum_wait_raw[SUM_W-1:0];
            sum_tat_ff   <= sum_tat_raw[SUM_W] ? SUM_MAX : sum_tat_raw[SUM_W-1:0];
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_SCAN) && tok[MAX_TASKS].go) begin
         pick_ff <= tok[MAX_TASKS];
      end
      if (state_ff == ST_CALC) begin
         fin_ff  <= pick_ff.found && pick_ff.last;
         comp_ff <= (pick_ff.found && pick_ff.last) ? time_next : '0;
         tat_ff  <= (pick_ff.found && pick_ff.last)
                    ? (time_next - TIME_W'(pick_ff.arrival)) : '0;
      end
      if ((state_ff == ST_SUM) && rsp_free) begin
         rsp_idle_ff     <= !pick_ff.found;
         rsp_slot_ff     <= pick_ff.found ? SLOT_W'(pick_ff.slot) : '0;
         rsp_fin_ff      <= fin_ff;
         rsp_comp_ff     <= comp_ff;
         rsp_tat_ff      <= tat_ff;
         rsp_wait_ff     <= wait_val;
         rsp_done_ff     <= (WIDE_W'(completed_ff) >= WIDE_W'(active));
         rsp_sum_wait_ff <= sum_wait_raw[SUM_W] ? SUM_MAX : sum_wait_raw[SUM_W-1:0];
         rsp_sum_tat_ff  <= sum_tat_raw[SUM_W] ? SUM_MAX : sum_tat_raw[SUM_W-1:0];
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.idle             = rsp_idle_ff;
   assign rsp_ch.ran_slot         = rsp_slot_ff;
   assign rsp_ch.finished         = rsp_fin_ff;
   assign rsp_ch.completion_time  = rsp_comp_ff;
   assign rsp_ch.turnaround       = rsp_tat_ff;
   assign rsp_ch.waiting          = rsp_wait_ff;
   assign rsp_ch.all_done         = rsp_done_ff;
   assign rsp_ch.total_waiting    = rsp_sum_wait_ff;
   assign rsp_ch.total_turnaround = rsp_sum_tat_ff;

`ifndef SYNTHESIS
   // the scan token only reaches the chain end while a scan is in progress
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[MAX_TASKS].go |-> (state_ff == ST_SCAN))
      else $error("scan token left chain outside a scan");

   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CALC) && pick_ff.found) |-> (CNT_W'(pick_ff.slot) < active))
      else $error("picked slot outside active range");

   a_time_monotone: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (time_ff >= $past(time_ff)))
      else $error("time went backwards");

   a_sum_monotone: assert property (@(posedge clock) disable iff (reset)
      !reset |=> ((sum_tat_ff >= $past(sum_tat_ff)) && (sum_wait_ff >= $past(sum_wait_ff))))
      else $error("running sum decreased");

   a_finish_not_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fin_ff) |-> !rsp_idle_ff)
      else $error("finished on an idle tick");
`endif

endmodule

// ===== hdl/psch_cell.sv =====
`timescale 1ns / 1ps
module psch_cell import psch_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [IDX_W-1:0]  idx,
   input  logic [CNT_W-1:0]  active,
   input  logic [TIME_W-1:0] cur_time,
   input  load_type          load,
   input  dec_type           dec,
   input  token_type         tok_in,
   output token_type         tok_out
);

   logic               valid_ff;
   logic [FIELD_W-1:0] prio_ff;
   logic [FIELD_W-1:0] arrival_ff;
   logic [FIELD_W-1:0] burst_ff;
   logic [FIELD_W-1:0] remain_ff;
   token_type          tok_ff;
   token_type          tok_in_next;
   logic               load_hit;
   logic               dec_hit;
   logic               ready_now;
   logic               take;

   assign load_hit  = load.we && (CMP_W'(load.slot) == CMP_W'(idx));
   assign dec_hit   = dec.strobe && (dec.slot == idx);
   assign ready_now = valid_ff && (CNT_W'(idx) < active)
                      && (TIME_W'(arrival_ff) <= cur_time) && (remain_ff != '0);
   assign take      = ready_now && (!tok_in.found || (prio_ff < tok_in.prio));

   always_comb begin
      tok_in_next = tok_in;
      if (take) begin
         tok_in_next.found   = 1'b1;
         tok_in_next.prio    = prio_ff;
         tok_in_next.slot    = idx;
         tok_in_next.arrival = arrival_ff;
         tok_in_next.burst   = burst_ff;
         tok_in_next.last    = (remain_ff == FIELD_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         tok_ff <= tok_in_next;
         if (load_hit) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         prio_ff    <= load.prio;
         arrival_ff <= load.arrival;
         burst_ff   <= load.burst;
         remain_ff  <= load.burst;
      end else if (dec_hit) begin
         remain_ff <= remain_ff - FIELD_W'(1);
      end
   end

   assign tok_out = tok_ff;

endmodule
